// ===== hdl/stg_pkg.sv =====
// Package for the scale tone generator: shared types, register defaults and codes.
// Also holds the elaboration-time builders for the pitch and sine tables.
// No dependencies.
package stg_pkg;

   localparam int PHASE_BITS_DEFAULT      = 32;
   localparam int SINE_TABLE_BITS_DEFAULT = 10;
   localparam int SAMPLE_RATE_DEFAULT     = 8000;

   localparam int KEY_BITS    = 7;
   localparam int MODE_BITS   = 2;
   localparam int COUNT_BITS  = 16;
   localparam int POS_BITS    = 3;
   localparam int SAMPLE_BITS = 8;
   localparam int CSR_BITS    = 16;
   localparam int KEY_COUNT   = 2 ** KEY_BITS;

   localparam logic [KEY_BITS-1:0]   TONIC_KEY_RESET        = 7'd40;
   localparam logic [MODE_BITS-1:0]  SCALE_MODE_RESET       = 2'd3;
   localparam logic [COUNT_BITS-1:0] SAMPLES_PER_NOTE_RESET = 16'd10000;

   localparam logic [KEY_BITS-1:0] TONIC_KEY_MIN = 7'd1;
   localparam logic [KEY_BITS-1:0] TONIC_KEY_MAX = 7'd88;
   localparam int PITCH_KEY_MIN = 1;
   localparam int PITCH_KEY_MAX = 100;

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;
   localparam logic [63:0] PI_Q32  = 64'd13493037705;

   // keys 89..100 in Q16
   localparam logic [31:0] TOP_OCTAVE_Q16 [12] = '{
      32'd290647054, 32'd307929828, 32'd326240288, 32'd345639545,
      32'd366192348, 32'd387967272, 32'd411037006, 32'd435478539,
      32'd461373440, 32'd488808132, 32'd517874176, 32'd548668578
   };

   typedef enum logic [1:0] {
      CSR_TONIC_KEY        = 2'd0,
      CSR_SCALE_MODE       = 2'd1,
      CSR_SAMPLES_PER_NOTE = 2'd2
   } csr_index_type;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_DIATONIC       = 2'd0,
      MODE_HARMONIC_MINOR = 2'd1,
      MODE_MELODIC_MINOR  = 2'd2,
      MODE_PENTATONIC     = 2'd3
   } scale_mode_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   tonic_key;
      logic [MODE_BITS-1:0]  scale_mode;
      logic [COUNT_BITS-1:0] samples_per_note;
   } cfg_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] note_key;
      logic [POS_BITS-1:0] note_index;
      logic                last_of_note;
      logic                last_of_scale;
   } note_info_type;

   function automatic logic [POS_BITS-1:0] pattern_len(input logic [MODE_BITS-1:0] mode);
      logic [POS_BITS-1:0] len;
      case (mode)
         MODE_PENTATONIC: len = 3'd5;
         default:         len = 3'd7;
      endcase
      return len;
   endfunction

   function automatic logic [1:0] step_size(input logic [MODE_BITS-1:0] mode,
                                           input logic [POS_BITS-1:0]  pos);
      logic [1:0] st;
      st = 2'd0;
      case (mode)
         MODE_DIATONIC: begin
            case (pos)
               3'd2, 3'd6: st = 2'd1;
               3'd7:       st = 2'd0;
               default:    st = 2'd2;
            endcase
         end
         MODE_HARMONIC_MINOR: begin
            case (pos)
               3'd1, 3'd4, 3'd6: st = 2'd1;
               3'd5:             st = 2'd3;
               3'd7:             st = 2'd0;
               default:          st = 2'd2;
            endcase
         end
         MODE_MELODIC_MINOR: begin
            case (pos)
               3'd1, 3'd6: st = 2'd1;
               3'd7:       st = 2'd0;
               default:    st = 2'd2;
            endcase
         end
         default: begin
            case (pos)
               3'd2, 3'd4: st = 2'd3;
               3'd0, 3'd1, 3'd3: st = 2'd2;
               default:    st = 2'd0;
            endcase
         end
      endcase
      return st;
   endfunction

   // Rounded phase increment for a key, built at elaboration by restoring division.
   function automatic logic [63:0] key_increment(input int key, input int phase_bits,
                                                 input int sample_rate);
      int           k;
      int           d;
      int           sh;
      logic [63:0]  num;
      logic [63:0]  den;
      logic [63:0]  r;
      logic [127:0] dividend;
      logic [127:0] q;
      logic [63:0]  res;
      logic [63:0]  mask;
      k = key;
      if (k < PITCH_KEY_MIN) k = PITCH_KEY_MIN;
      if (k > PITCH_KEY_MAX) k = PITCH_KEY_MAX;
      d   = PITCH_KEY_MAX - k;
      sh  = d / 12;
      num = 64'(TOP_OCTAVE_Q16[11 - (d % 12)]);
      den = 64'(sample_rate) << (16 + sh);
      dividend = 128'(num) << (phase_bits + 1);
      r = 64'd0;
      q = 128'd0;
      for (int i = 127; i >= 0; i--) begin
         r = {r[62:0], dividend[i]};
         if (r >= den) begin
            r = r - den;
            q[i] = 1'b1;
         end
      end
      res  = 64'((q + 128'd1) >> 1);
      mask = (64'd1 << phase_bits) - 64'd1;
      return res & mask;
   endfunction

   function automatic logic [63:0] sine_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         term = (term * x2) >> 30;
         case (n)
            1:       term = term / 64'd6;
            2:       term = term / 64'd20;
            3:       term = term / 64'd42;
            4:       term = term / 64'd72;
            5:       term = term / 64'd110;
            6:       term = term / 64'd156;
            default: term = term / 64'd210;
         endcase
         if ((n % 2) == 1) sum = sum - longint'(term);
         else              sum = sum + longint'(term);
      end
      if (sum < 0) return 64'd0;
      if (64'(sum) > Q30_ONE) return Q30_ONE;
      return 64'(sum);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] sine_sample(input int idx, input int table_bits);
      int          quarter;
      int          quad;
      int          j;
      logic [63:0] x;
      logic [63:0] s;
      logic [63:0] v;
      quarter = 1 << (table_bits - 2);
      quad    = (idx >> (table_bits - 2)) & 3;
      j       = idx & (quarter - 1);
      if ((quad & 1) != 0) j = quarter - j;
      if (j == 0) begin
         s = 64'd0;
      end else if (j == quarter) begin
         s = Q30_ONE;
      end else begin
         x = (64'd2 * PI_Q32 * 64'(j)) >> (table_bits + 2);
         s = sine_q30(x);
      end
      v = (quad >= 2) ? (Q30_ONE - s) : (Q30_ONE + s);
      return SAMPLE_BITS'((v * 64'd127) >> 30);
   endfunction

endpackage

// ===== hdl/stg_sequencer.sv =====
// Note sequencer: tracks key, note position, sample count and phase per tick.
// Holds the key-to-increment table. Depends on stg_pkg.
module stg_sequencer #(
   parameter int PHASE_BITS      = stg_pkg::PHASE_BITS_DEFAULT,
   parameter int SINE_TABLE_BITS = stg_pkg::SINE_TABLE_BITS_DEFAULT,
   parameter int SAMPLE_RATE     = stg_pkg::SAMPLE_RATE_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       restart,
   input  stg_pkg::cfg_type           cfg,
   output logic                       produce,
   output stg_pkg::note_info_type     info,
   output logic [SINE_TABLE_BITS-1:0] sine_index
);

   logic [PHASE_BITS-1:0] inc_rom [stg_pkg::KEY_COUNT];

   for (genvar k = 0; k < stg_pkg::KEY_COUNT; k++) begin : g_inc
      localparam logic [63:0] INC_FULL =
         stg_pkg::key_increment(k, PHASE_BITS, SAMPLE_RATE);
      assign inc_rom[k] = INC_FULL[PHASE_BITS-1:0];
   end

   logic [PHASE_BITS-1:0]          phase_ff, phase_in, eff_phase;
   logic [stg_pkg::COUNT_BITS-1:0] count_ff, count_in, eff_count, spn;
   logic [stg_pkg::POS_BITS-1:0]   pos_ff, pos_in, eff_pos;
   logic [stg_pkg::KEY_BITS-1:0]   key_ff, key_in, eff_key, tonic;
   logic                           active_ff, active_in, eff_active;
   logic                           end_note, end_scale;

   always_comb begin
      tonic = cfg.tonic_key;
      if (tonic < stg_pkg::TONIC_KEY_MIN) tonic = stg_pkg::TONIC_KEY_MIN;
      if (tonic > stg_pkg::TONIC_KEY_MAX) tonic = stg_pkg::TONIC_KEY_MAX;
      spn = (cfg.samples_per_note == '0) ? 16'd1 : cfg.samples_per_note;

      if (restart) begin
         eff_key    = tonic;
         eff_pos    = '0;
         eff_count  = '0;
         eff_phase  = '0;
         eff_active = 1'b1;
      end else begin
         eff_key    = key_ff;
         eff_pos    = pos_ff;
         eff_count  = count_ff;
         eff_phase  = phase_ff;
         eff_active = active_ff;
      end

      end_note  = ({1'b0, eff_count} + 17'd1) >= {1'b0, spn};
      end_scale = end_note && (eff_pos >= stg_pkg::pattern_len(cfg.scale_mode));

      phase_in  = phase_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      key_in    = key_ff;
      active_in = active_ff;
      if (accept && eff_active) begin
         phase_in  = eff_phase;
         count_in  = eff_count;
         pos_in    = eff_pos;
         key_in    = eff_key;
         active_in = 1'b1;
         if (end_scale) begin
            active_in = 1'b0;
         end else if (end_note) begin
            key_in   = eff_key + 7'(stg_pkg::step_size(cfg.scale_mode, eff_pos));
            pos_in   = eff_pos + 3'd1;
            count_in = '0;
            phase_in = '0;
         end else begin
            count_in = eff_count + 16'd1;
            phase_in = eff_phase + inc_rom[eff_key];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         count_ff  <= '0;
         pos_ff    <= '0;
         key_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
         key_ff    <= key_in;
         active_ff <= active_in;
      end
   end

   assign produce            = accept && eff_active;
   assign info.note_key      = eff_key;
   assign info.note_index    = eff_pos;
   assign info.last_of_note  = end_note;
   assign info.last_of_scale = end_scale;
   assign sine_index         = eff_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];

endmodule

// ===== hdl/scale_tone_generator.sv =====
// Top level of the scale tone generator: configuration registers, sine ROM,
// output register with skid stage. Depends on stg_pkg and stg_sequencer.
// Results are registered in the output register, or the skid stage if stalled.
// Throughput: one tick per cycle while req_stall is low.
// Reset: synchronous; block idle, registers at defaults, no words pending.
// req_stall rises only while the skid stage holds a word.
module scale_tone_generator #(
   parameter int PHASE_BITS      = stg_pkg::PHASE_BITS_DEFAULT,
   parameter int SINE_TABLE_BITS = stg_pkg::SINE_TABLE_BITS_DEFAULT,
   parameter int SAMPLE_RATE     = stg_pkg::SAMPLE_RATE_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [stg_pkg::SAMPLE_BITS-1:0]   rsp_sample,
   output logic [stg_pkg::KEY_BITS-1:0]      rsp_note_key,
   output logic [stg_pkg::POS_BITS-1:0]      rsp_note_index,
   output logic                              rsp_last_of_note,
   output logic                              rsp_last_of_scale,
   input  logic                              csr_wr_en,
   input  logic [1:0]                        csr_index,
   input  logic [stg_pkg::CSR_BITS-1:0]      csr_wdata
);

   localparam int SINE_DEPTH = 2 ** SINE_TABLE_BITS;

   stg_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tonic_key        <= stg_pkg::TONIC_KEY_RESET;
         cfg_ff.scale_mode       <= stg_pkg::SCALE_MODE_RESET;
         cfg_ff.samples_per_note <= stg_pkg::SAMPLES_PER_NOTE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            stg_pkg::CSR_TONIC_KEY:
               cfg_ff.tonic_key <= csr_wdata[stg_pkg::KEY_BITS-1:0];
            stg_pkg::CSR_SCALE_MODE:
               cfg_ff.scale_mode <= csr_wdata[stg_pkg::MODE_BITS-1:0];
            stg_pkg::CSR_SAMPLES_PER_NOTE:
               cfg_ff.samples_per_note <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [stg_pkg::SAMPLE_BITS-1:0] sine_rom [SINE_DEPTH];

   for (genvar j = 0; j < SINE_DEPTH; j++) begin : g_sine
      assign sine_rom[j] = stg_pkg::sine_sample(j, SINE_TABLE_BITS);
   end

   logic                       accept;
   logic                       produce;
   stg_pkg::note_info_type     new_info;
   logic [SINE_TABLE_BITS-1:0] sine_index;

   logic                            main_valid_ff, main_valid_in;
   logic                            skid_valid_ff, skid_valid_in;
   stg_pkg::note_info_type          main_info_ff, skid_info_ff;
   logic [stg_pkg::SAMPLE_BITS-1:0] main_sample_ff, skid_sample_ff;
   logic                            drain, move_skid, load_main, load_skid;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;

   stg_sequencer #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_RATE     (SAMPLE_RATE)
   ) u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .restart    (req_restart),
      .cfg        (cfg_ff),
      .produce    (produce),
      .info       (new_info),
      .sine_index (sine_index)
   );

   always_comb begin
      drain     = main_valid_ff && !rsp_stall;
      move_skid = skid_valid_ff && drain;
      load_main = produce && (!main_valid_ff || drain);
      load_skid = produce && main_valid_ff && !drain;

      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (move_skid) begin
         skid_valid_in = 1'b0;
      end else if (load_main) begin
         main_valid_in = 1'b1;
      end else if (load_skid) begin
         skid_valid_in = 1'b1;
      end else if (drain) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move_skid) begin
         main_info_ff   <= skid_info_ff;
         main_sample_ff <= skid_sample_ff;
      end else if (load_main) begin
         main_info_ff   <= new_info;
         main_sample_ff <= sine_rom[sine_index];
      end
      if (load_skid) begin
         skid_info_ff   <= new_info;
         skid_sample_ff <= sine_rom[sine_index];
      end
   end

   assign rsp_valid         = main_valid_ff;
   assign rsp_sample        = main_sample_ff;
   assign rsp_note_key      = main_info_ff.note_key;
   assign rsp_note_index    = main_info_ff.note_index;
   assign rsp_last_of_note  = main_info_ff.last_of_note;
   assign rsp_last_of_scale = main_info_ff.last_of_scale;

endmodule
